// File: rtl/hnt_pkg.sv
`default_nettype none

package hnt_pkg;

	// Default table depth.
	localparam int MAX_NOTES_DEF = 16;

	// Configuration register map.
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_NOTE_ON  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFF = 1'b1;

	localparam logic [7:0] NOTE_ON_RST  = 8'd144;
	localparam logic [7:0] NOTE_OFF_RST = 8'd128;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] key_number;
		logic [7:0] key_velocity;
	} msg_t;

	typedef struct packed {
		logic       changed;
		logic       refused_full;
		logic [4:0] held_count;
		logic [7:0] mean_velocity;
		logic       mean_valid;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic take_off;
		logic append;
		logic refuse;
		logic shift_wr;
		logic shrink;
		logic div_init;
		logic div_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_on;
		logic is_off;
		logic hit;
		logic miss;
		logic full;
		logic shift_end;
		logic div_end;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/hnt_ctrl.sv
`default_nettype none

module hnt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire hnt_pkg::stat_t stat,
	output hnt_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import hnt_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SCAN     = 7'b0000010,
		ST_SHIFT_RD = 7'b0000100,
		ST_SHIFT_WR = 7'b0001000,
		ST_DIV_INIT = 7'b0010000,
		ST_DIV      = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!stat.is_on && !stat.is_off) begin
					state_d = ST_DIV_INIT;
				end else if (stat.hit) begin
					if (stat.is_off) begin
						cmd.take_off = 1'b1;
						state_d      = ST_SHIFT_RD;
					end else begin
						state_d = ST_DIV_INIT;
					end
				end else if (stat.miss) begin
					if (stat.is_on) begin
						cmd.append = !stat.full;
						cmd.refuse = stat.full;
					end
					state_d = ST_DIV_INIT;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_SHIFT_RD: begin
				if (stat.shift_end) begin
					cmd.shrink = 1'b1;
					state_d    = ST_DIV_INIT;
				end else begin
					state_d = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// An accepted transaction always makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not start work");

	// After the result strobe the block is free again.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe not followed by idle");

	// Exactly one state bit is set at any time.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

endmodule

`default_nettype wire

// File: rtl/hnt_dpath.sv
`default_nettype none

module hnt_dpath #(
	parameter int MAX_NOTES = hnt_pkg::MAX_NOTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hnt_pkg::cmd_t   cmd,
	input  wire hnt_pkg::msg_t   msg,
	input  wire logic [7:0]      note_on_code,
	input  wire logic [7:0]      note_off_code,
	output hnt_pkg::stat_t       stat,
	output hnt_pkg::result_t     result
);
	import hnt_pkg::*;

	localparam int CNTW = $clog2(MAX_NOTES + 1);
	localparam int AW   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int SUMW = 8 + $clog2(MAX_NOTES);
	localparam int DCW  = (SUMW > 1) ? $clog2(SUMW) : 1;

	// Note table memory.
	logic [7:0] key_mem_q [MAX_NOTES];
	logic [7:0] vel_mem_q [MAX_NOTES];

	logic [7:0]      rd_key_q, rd_vel_q;
	logic            rd_vld_q;
	logic [7:0]      op_key_q, op_vel_q;
	logic            is_on_q, is_off_q;
	logic [CNTW-1:0] count_q, idx_q;
	logic [SUMW-1:0] total_q;
	logic            changed_q, refused_q;
	logic [SUMW-1:0] quo_q;
	logic [CNTW-1:0] rem_q;
	logic [DCW-1:0]  div_cnt_q;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_key, wr_vel;
	logic [CNTW-1:0] idx_m1;
	logic [CNTW:0]   trial, trial_sub;
	logic            trial_ge;
	logic [CNTW+4:0] cnt_ext;

	assign idx_m1 = idx_q - 1'b1;

	// Status toward the controller.
	always_comb begin
		stat.is_on     = is_on_q;
		stat.is_off    = is_off_q;
		stat.hit       = rd_vld_q && (rd_key_q == op_key_q);
		stat.miss      = !stat.hit && (idx_q == count_q);
		stat.full      = (count_q == CNTW'(MAX_NOTES));
		stat.shift_end = (idx_q >= count_q);
		stat.div_end   = (div_cnt_q == DCW'(SUMW - 1));
	end

	// One write port: append at the tail or move an entry one place toward the front.
	assign wr_en   = cmd.append || cmd.shift_wr;
	assign wr_addr = cmd.append ? count_q[AW-1:0] : idx_m1[AW-1:0];
	assign wr_key  = cmd.append ? op_key_q : rd_key_q;
	assign wr_vel  = cmd.append ? op_vel_q : rd_vel_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem_q[wr_addr] <= wr_key;
			vel_mem_q[wr_addr] <= wr_vel;
		end
		rd_key_q <= key_mem_q[idx_q[AW-1:0]];
		rd_vel_q <= vel_mem_q[idx_q[AW-1:0]];
	end

	// Transaction operands.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_key_q <= msg.key_number;
			op_vel_q <= msg.key_velocity;
		end
	end

	// Table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			total_q   <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			is_on_q   <= 1'b0;
			is_off_q  <= 1'b0;
			changed_q <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.scan;
			if (cmd.load) begin
				is_on_q   <= (msg.status_byte == note_on_code);
				is_off_q  <= (msg.status_byte != note_on_code) &&
				             (msg.status_byte == note_off_code);
				idx_q     <= '0;
				changed_q <= 1'b0;
				refused_q <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.take_off) begin
				total_q <= total_q - SUMW'(rd_vel_q);
			end
			if (cmd.append) begin
				count_q   <= count_q + 1'b1;
				total_q   <= total_q + SUMW'(op_vel_q);
				changed_q <= 1'b1;
			end
			if (cmd.refuse) begin
				refused_q <= 1'b1;
			end
			if (cmd.shift_wr) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.shrink) begin
				count_q   <= count_q - 1'b1;
				changed_q <= 1'b1;
			end
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign trial     = {rem_q, quo_q[SUMW-1]};
	assign trial_ge  = (trial >= {1'b0, count_q});
	assign trial_sub = trial - {1'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q     <= total_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q     <= {quo_q[SUMW-2:0], trial_ge};
			rem_q     <= trial_ge ? trial_sub[CNTW-1:0] : trial[CNTW-1:0];
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	assign cnt_ext = {5'b0, count_q};

	always_comb begin
		result.changed       = changed_q;
		result.refused_full  = refused_q;
		result.held_count    = cnt_ext[4:0];
		result.mean_valid    = (count_q != '0);
		result.mean_velocity = result.mean_valid ? quo_q[7:0] : 8'd0;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_NOTES))
		else $error("entry count beyond table depth");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= 32'(count_q) * 32'd255)
		else $error("velocity total exceeds what the held notes allow");

	a_take_off_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_off |-> stat.hit && is_off_q)
		else $error("removal without a matching key");

endmodule

`default_nettype wire

// File: rtl/held_note_table_top.sv
`default_nettype none

// Held-note table: tracks which MIDI keys are down, in the order they were pressed.
// Input: one three-byte message per transaction on msg, taken at a rising edge with
// start high and busy low. A header equal to the note-on code appends the key and
// velocity unless the key is already held or the table is full (then refused_full);
// a header equal to the note-off code removes the first matching entry and closes
// the gap. Any other header leaves the table alone but still gives a result.
// Output: every transaction gives one result, shown on result for exactly one cycle
// while done is high. The receiver cannot hold it off, and busy stays high until the
// cycle after done, so nothing is ever lost or overwritten.
// Sequence: the key scan reads the held entries one at a time; after a note-off that
// finds its key, the gap is closed by moving each later entry one place toward the
// front. Then a setup state and a restoring divider, one quotient bit per cycle for
// 8+clog2(MAX_NOTES) quotient bits, form the mean velocity, and done follows.
// The scan and the gap closing are bound by the single read port of the note table.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 note-on code,
// 1 note-off code) at once; write only while busy is low.
// Reset: arst_n empties the table and restores codes 144 and 128; table contents
// need no clearing since only entries below the count are read.

module held_note_table_top #(
	parameter int MAX_NOTES = hnt_pkg::MAX_NOTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire hnt_pkg::msg_t                msg,
	output logic                              busy,
	output logic                              done,
	output hnt_pkg::result_t                  result,
	input  wire logic                         cfg_we,
	input  wire logic [hnt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hnt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hnt_pkg::*;

	logic [7:0] note_on_q, note_off_q;
	cmd_t       cmd;
	stat_t      stat;

	// Configuration registers, written directly by the plain write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_on_q  <= NOTE_ON_RST;
			note_off_q <= NOTE_OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOTE_ON:  note_on_q  <= cfg_data;
				REG_NOTE_OFF: note_off_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// The controller sequences scan, gap closing and division.
	hnt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath owns the note table, the running totals and the divider.
	hnt_dpath #(
		.MAX_NOTES (MAX_NOTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.msg           (msg),
		.note_on_code  (note_on_q),
		.note_off_code (note_off_q),
		.stat          (stat),
		.result        (result)
	);

endmodule

`default_nettype wire

// File: test/tb_held_note_table_top.sv
`timescale 1ns / 100ps

// Scoreboard for the held-note table. It keeps its own copy of the note table
// and of the two header codes, works out the result of every accepted message
// and checks each result from the block against the oldest one waiting.
class held_note_board;
	logic [7:0] on_code;
	logic [7:0] off_code;
	logic [7:0] keys [hnt_pkg::MAX_NOTES_DEF];
	logic [7:0] vels [hnt_pkg::MAX_NOTES_DEF];
	int unsigned held;
	int unsigned vel_sum;
	hnt_pkg::result_t pending_results[$];
	int unsigned error_count;
	int unsigned results_seen;
	int unsigned adds;
	int unsigned removes;
	int unsigned refusals;
	int unsigned peak;

	function new();
		on_code = hnt_pkg::NOTE_ON_RST;
		off_code = hnt_pkg::NOTE_OFF_RST;
		held = 0;
		vel_sum = 0;
		error_count = 0;
		results_seen = 0;
		adds = 0;
		removes = 0;
		refusals = 0;
		peak = 0;
	endfunction

	function void set_codes(logic [7:0] on_value, logic [7:0] off_value);
		on_code = on_value;
		off_code = off_value;
	endfunction

	function int find_key(logic [7:0] key);
		for (int i = 0; i < held; i++) begin
			if (keys[i] == key) begin
				return i;
			end
		end
		return -1;
	endfunction

	function logic [7:0] held_key(int unsigned idx);
		return keys[idx];
	endfunction

	function int unsigned pending_count();
		return pending_results.size();
	endfunction

	// An accepted message: update the table and queue the result it must give.
	function void note_message(hnt_pkg::msg_t m);
		hnt_pkg::result_t r;
		int pos;
		r = '0;
		if (m.status_byte == on_code) begin
			if (find_key(m.key_number) < 0) begin
				if (held < hnt_pkg::MAX_NOTES_DEF) begin
					keys[held] = m.key_number;
					vels[held] = m.key_velocity;
					held++;
					vel_sum += m.key_velocity;
					r.changed = 1'b1;
					adds++;
				end else begin
					r.refused_full = 1'b1;
					refusals++;
				end
			end
		end else if (m.status_byte == off_code) begin
			pos = find_key(m.key_number);
			if (pos >= 0) begin
				vel_sum -= vels[pos];
				for (int i = pos; i + 1 < held; i++) begin
					keys[i] = keys[i + 1];
					vels[i] = vels[i + 1];
				end
				held--;
				r.changed = 1'b1;
				removes++;
			end
		end
		if (held > peak) begin
			peak = held;
		end
		r.held_count = 5'(held);
		r.mean_valid = (held != 0);
		r.mean_velocity = (held != 0) ? 8'(vel_sum / held) : 8'd0;
		pending_results = {pending_results, r};
	endfunction

	// A result from the block: compare it field by field with the oldest one due.
	function void check_result(hnt_pkg::result_t got);
		hnt_pkg::result_t want;
		bit bad;
		results_seen++;
		if (pending_results.size() == 0) begin
			error_count++;
			if (error_count <= 10) begin
				$display("Result %0d arrived with no message waiting for it.", results_seen);
			end
			return;
		end
		want = pending_results.pop_front();
		bad = (got.changed !== want.changed) || (got.refused_full !== want.refused_full)
			|| (got.held_count !== want.held_count)
			|| (got.mean_velocity !== want.mean_velocity)
			|| (got.mean_valid !== want.mean_valid);
		if (bad) begin
			error_count++;
			if (error_count <= 10) begin
				$display("Result %0d wrong:", results_seen);
				$display("  expected changed=%0b refused=%0b count=%0d mean=%0d valid=%0b",
					want.changed, want.refused_full, want.held_count,
					want.mean_velocity, want.mean_valid);
				$display("  got changed=%0b refused=%0b count=%0d mean=%0d valid=%0b",
					got.changed, got.refused_full, got.held_count, got.mean_velocity,
					got.mean_valid);
			end
		end
	endfunction
endclass

module tb_held_note_table_top;
	import hnt_pkg::*;

	// Every input is known from time zero; reset is held low first and then released.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	msg_t msg = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_NOTE_ON;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	result_t result;

	// While quiet is set the sender never idles between transactions.
	bit quiet = 1'b0;
	int unsigned sent = 0;
	int unsigned settings_used = 0;
	held_note_board board = new();

	held_note_table_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.msg       (msg),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// The receiver cannot stall the block, so every cycle with done high carries
	// one result. Outputs are sampled at the edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(result);
		end
	end

	// Offer one message and hold it until the block takes it. The transaction
	// happens at the edge where start is high and busy was low. Afterwards the
	// sender idles now and then, so gaps land on every stage of the block's work.
	task automatic send_message(input msg_t m);
		start <= 1'b1;
		msg <= m;
		do @(posedge clk); while (busy);
		board.note_message(m);
		sent++;
		if (!quiet && $urandom_range(0, 99) < 29) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every queued result has come and the block is idle.
	// Every message gives a result, so an empty queue plus busy low means idle.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (board.pending_count() != 0 || busy);
	endtask

	// Write both header codes; only ever done with the block idle.
	task automatic set_codes(input logic [7:0] on_value, input logic [7:0] off_value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_NOTE_ON;
		cfg_data <= on_value;
		@(posedge clk);
		cfg_index <= REG_NOTE_OFF;
		cfg_data <= off_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_codes(on_value, off_value);
		settings_used++;
	endtask

	function automatic msg_t make_msg(logic [7:0] s, logic [7:0] k, logic [7:0] v);
		return msg_t'({s, k, v});
	endfunction

	// Mostly well-formed note traffic over a small key pool, so the table fills,
	// empties and sees duplicates often. Note-offs usually name a key that is held.
	// About one message in seven carries an arbitrary header.
	function automatic msg_t random_message(int unsigned on_pct, logic [7:0] key_base);
		msg_t m;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		m.key_velocity = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) < 7) begin
			m.key_number = key_base + 8'($urandom_range(0, 19));
		end else begin
			m.key_number = 8'($urandom_range(0, 255));
		end
		if (pick < on_pct) begin
			m.status_byte = board.on_code;
		end else if (pick < 85) begin
			m.status_byte = board.off_code;
			if (board.held != 0 && $urandom_range(0, 9) < 6) begin
				m.key_number = board.held_key($urandom_range(0, board.held - 1));
			end
		end else begin
			m.status_byte = 8'($urandom_range(0, 255));
		end
		return m;
	endfunction

	// Stimulus. The code settings cover the reset values, both extremes in either
	// order, equal codes at the extremes and in between, and one random pair.
	initial begin
		logic [7:0] on_list [8];
		logic [7:0] off_list [8];
		logic [7:0] key_base;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset codes: note-off and stray headers on an
		// empty table, the extreme keys and velocities, a duplicate note-on,
		// filling the table, a refused note-on, a duplicate on a full table,
		// a note-off for a key not held, removals from the middle, the front
		// and the back, then a note-on that lands in the closed-up table.
		send_message(make_msg(8'h80, 8'h00, 8'h00));
		send_message(make_msg(8'h00, 8'h00, 8'h00));
		send_message(make_msg(8'hFF, 8'hFF, 8'hFF));
		send_message(make_msg(8'h90, 8'h00, 8'h00));
		send_message(make_msg(8'h90, 8'hFF, 8'hFF));
		send_message(make_msg(8'h90, 8'h00, 8'h07));
		for (int k = 1; k <= 14; k++) begin
			send_message(make_msg(8'h90, 8'(k), 8'(k * 18)));
		end
		send_message(make_msg(8'h90, 8'hC8, 8'h40));
		send_message(make_msg(8'h90, 8'hFF, 8'h01));
		send_message(make_msg(8'h80, 8'h4D, 8'h00));
		send_message(make_msg(8'h80, 8'hFF, 8'h00));
		send_message(make_msg(8'h80, 8'h00, 8'h00));
		send_message(make_msg(8'h80, 8'h0E, 8'h00));
		send_message(make_msg(8'h90, 8'hC8, 8'h40));

		// Equal codes: the shared header must act as note-on.
		set_codes(8'h55, 8'h55);
		send_message(make_msg(8'h55, 8'hA0, 8'h33));
		send_message(make_msg(8'h55, 8'h01, 8'h00));

		on_list  = '{8'd144, 8'd0,   8'd255, 8'h9A, 8'd255, 8'h00, 8'd144, 8'd0};
		off_list = '{8'd128, 8'd255, 8'd0,   8'h9A, 8'd255, 8'h00, 8'd128, 8'd0};
		on_list[5] = 8'($urandom_range(0, 255));
		off_list[5] = 8'($urandom_range(0, 255));

		for (int p = 0; p < 8; p++) begin
			set_codes(on_list[p], off_list[p]);
			key_base = 8'($urandom_range(0, 255));
			for (int i = 0; i < 230; i++) begin
				// Halfway through each phase the sender holds off until the
				// block has delivered everything.
				if (i == 115) begin
					wait_drained();
				end
				quiet = (sent >= 700 && sent < 1000);
				send_message(random_message((p % 2 == 1) ? 30 : 50, key_base));
			end
		end

		wait_drained();
		repeat (70) @(posedge clk);

		$display("Sent %0d messages under %0d code settings; the table held up to %0d notes.",
			sent, settings_used, board.peak);
		$display("Notes added %0d, removed %0d, refused when full %0d; mismatches %0d.",
			board.adds, board.removes, board.refusals, board.error_count);
		if (board.pending_count() != 0) begin
			$display("%0d results never arrived.", board.pending_count());
		end
		if (board.error_count == 0 && board.pending_count() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#15000000;
		$display("Run did not finish in time.");
		$display("FAILURE");
		$finish;
	end

endmodule
